### sv/ptl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_pkg
// Shared field widths, operation codes and failure verdict codes of the
// pending work ticket ledger.
// ----------------------------------------------------------------------------
package ptl_pkg;

  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned FID_W     = 10;
  localparam int unsigned TKT_W     = 32;
  localparam int unsigned RETRY_W   = 4;
  localparam int unsigned VERDICT_W = 2;

  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd3;

  typedef enum logic [FUNC_W-1:0] {
    FN_RECORD  = 3'd0,
    FN_CLAIM   = 3'd1,
    FN_PEEK    = 3'd2,
    FN_SETTLE  = 3'd3,
    FN_QUERY   = 3'd4,
    FN_FAILURE = 3'd5
  } func_e;

  typedef enum logic [VERDICT_W-1:0] {
    VERD_DROPPED    = 2'd0,
    VERD_SUPERSEDED = 2'd1,
    VERD_GAVE_UP    = 2'd2,
    VERD_REQUEUED   = 2'd3
  } verdict_e;

endpackage

### sv/ptl_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_req_if
// Request channel of the ledger: one operation item per handshake.
// ----------------------------------------------------------------------------
interface ptl_req_if;
  import ptl_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [FID_W-1:0]   file_id;
  logic               change_kind;
  logic [TKT_W-1:0]   claim_ticket;
  logic               crashed;

  modport source (
    output valid, func, file_id, change_kind, claim_ticket, crashed,
    input  ready
  );

  modport sink (
    input  valid, func, file_id, change_kind, claim_ticket, crashed,
    output ready
  );
endinterface

### sv/ptl_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_rsp_if
// Result channel of the ledger: one result item per request item.
// ----------------------------------------------------------------------------
interface ptl_rsp_if;
  import ptl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 slot_needed;
  logic                 found;
  logic [TKT_W-1:0]     ticket_out;
  logic                 is_superseded;
  logic [VERDICT_W-1:0] verdict;

  modport source (
    output valid, slot_needed, found, ticket_out, is_superseded, verdict,
    input  ready
  );

  modport sink (
    input  valid, slot_needed, found, ticket_out, is_superseded, verdict,
    output ready
  );
endinterface

### sv/ptl_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_cfg_if
// Configuration write channel carrying the retry limit.
// ----------------------------------------------------------------------------
interface ptl_cfg_if;
  import ptl_pkg::*;

  logic               valid;
  logic               ready;
  logic [RETRY_W-1:0] data;

  modport source (
    output valid, data,
    input  ready
  );

  modport sink (
    input  valid, data,
    output ready
  );
endinterface

### sv/pending_work_ticket_ledger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_work_ticket_ledger
// Per-id ledger of pending work with a wrapping global ticket counter.
//
// Channels: req_i takes one operation item (record, claim, peek, settle,
// superseded query, dispatch failure) per valid/ready handshake; rsp_o gives
// exactly one result item per request, in order; cfg_i writes the retry
// limit and is always ready.
// Path: an accepted request is registered into the work stage; its result
// is registered into the output register as the work stage advances.
// Throughput: one item per cycle while rsp_o is not held. The entry table
// is a single-port-write, registered-read memory; each item reads its
// entry at acceptance and writes it back as it leaves the work stage, with
// a one-entry bypass for back-to-back items on the same id.
// Reset: the counter clears and the limit returns to 3, then a clearing
// pass writes every table entry empty, one per cycle, while req_i.ready
// stays low.
// Stall: while rsp_o is held, the item in the work stage holds and
// req_i.ready drops; a new item is taken in the cycle the result leaves.
// ----------------------------------------------------------------------------
module pending_work_ticket_ledger #(
  parameter int unsigned ID_COUNT    = 1024,
  parameter int unsigned TICKET_BITS = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  ptl_req_if.sink   req_i,
  ptl_rsp_if.source rsp_o,
  ptl_cfg_if.sink   cfg_i
);
  import ptl_pkg::*;

  localparam int unsigned IDX_W   = $clog2(ID_COUNT);
  localparam bit          IS_POW2 = (ID_COUNT & (ID_COUNT - 1)) == 0;
  localparam bit          REDUCE  = !IS_POW2 && (ID_COUNT < (1 << FID_W));
  localparam int          MOD_TOP = REDUCE ? int'(FID_W) - int'(IDX_W) : 0;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ID_COUNT - 1);

  typedef struct packed {
    logic                   valid;
    logic                   queued;
    logic                   kind;
    logic [TICKET_BITS-1:0] ticket;
    logic [TICKET_BITS-1:0] mark;
    logic [RETRY_W-1:0]     retry;
  } entry_t;

  entry_t mem [ID_COUNT];

  logic                   clr_busy_q;
  logic [IDX_W-1:0]       clr_idx_q;
  logic [RETRY_W-1:0]     retry_limit_q;
  logic [TICKET_BITS-1:0] cnt_q, cnt_d;

  logic                   s1_valid_q;
  logic [FUNC_W-1:0]      s1_func_q;
  logic [IDX_W-1:0]       s1_id_q;
  logic                   s1_kind_q;
  logic [TICKET_BITS-1:0] s1_claim_q;
  logic                   s1_crashed_q;
  entry_t                 rd_q;
  entry_t                 fwd_q;
  logic                   fwd_hit_q;

  logic                   out_valid_q;
  logic                   out_slot_q;
  logic                   out_found_q;
  logic [TKT_W-1:0]       out_ticket_q;
  logic                   out_sup_q;
  logic [VERDICT_W-1:0]   out_verdict_q;

  logic [FID_W-1:0]       fid_rem;
  logic [IDX_W-1:0]       acc_id;
  logic                   accept;
  logic                   s1_adv;

  entry_t                 cur;
  entry_t                 nxt;
  logic                   do_rec;
  logic                   rec_kind;
  logic                   keep_retry;
  logic [RETRY_W-1:0]     retry_keep;
  logic [TICKET_BITS-1:0] tk;
  logic                   fresh;
  logic                   res_slot;
  logic                   res_found;
  logic [TKT_W-1:0]       res_ticket;
  logic                   res_sup;
  logic [VERDICT_W-1:0]   res_verdict;

  always_comb begin
    fid_rem = req_i.file_id;
    if (REDUCE) begin
      for (int k = MOD_TOP; k >= 0; k--) begin
        if (32'(fid_rem) >= 32'(ID_COUNT << k)) begin
          fid_rem = fid_rem - FID_W'(ID_COUNT << k);
        end
      end
    end
  end

  assign acc_id = IDX_W'(fid_rem);

  assign s1_adv = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign accept = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign cur = fwd_hit_q ? fwd_q : rd_q;

  always_comb begin
    nxt         = cur;
    do_rec      = 1'b0;
    rec_kind    = s1_kind_q;
    keep_retry  = 1'b0;
    retry_keep  = cur.retry;
    res_slot    = 1'b0;
    res_found   = 1'b0;
    res_ticket  = '0;
    res_sup     = 1'b0;
    res_verdict = VERD_DROPPED;
    tk          = cnt_q + TICKET_BITS'(1);
    fresh       = !cur.queued;
    cnt_d       = cnt_q;

    unique case (s1_func_q) inside
      FN_RECORD: begin
        do_rec = 1'b1;
      end
      FN_CLAIM, FN_PEEK: begin
        if (s1_func_q == FN_CLAIM) begin
          nxt.queued = 1'b0;
        end
        if (cur.valid) begin
          res_found  = 1'b1;
          res_ticket = TKT_W'(cur.ticket);
        end
      end
      FN_SETTLE: begin
        if (cur.valid && cur.ticket == s1_claim_q) begin
          nxt.valid = 1'b0;
        end
      end
      FN_QUERY: begin
        res_sup = !cur.valid || (cur.mark > s1_claim_q);
      end
      FN_FAILURE: begin
        if (!cur.valid) begin
          res_verdict = VERD_DROPPED;
        end else if (cur.mark > s1_claim_q) begin
          res_verdict = VERD_SUPERSEDED;
        end else if (s1_crashed_q && cur.retry >= retry_limit_q) begin
          nxt.valid   = 1'b0;
          nxt.queued  = 1'b0;
          res_verdict = VERD_GAVE_UP;
        end else begin
          if (s1_crashed_q) begin
            retry_keep = cur.retry + RETRY_W'(1);
          end
          keep_retry  = 1'b1;
          do_rec      = 1'b1;
          rec_kind    = (cur.mark == s1_claim_q) ? 1'b1 : cur.kind;
          res_verdict = VERD_REQUEUED;
        end
      end
      default: begin
      end
    endcase

    if (do_rec) begin
      cnt_d      = tk;
      res_slot   = fresh;
      nxt.queued = 1'b1;
      if (!cur.valid) begin
        nxt.valid = 1'b1;
        nxt.kind  = rec_kind;
        nxt.mark  = rec_kind ? tk : '0;
        nxt.retry = '0;
      end else if (rec_kind) begin
        nxt.kind  = 1'b1;
        nxt.mark  = tk;
        nxt.retry = '0;
      end else if (fresh) begin
        nxt.kind = 1'b0;
      end
      nxt.ticket = tk;
      if (keep_retry) begin
        nxt.retry = retry_keep;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_idx_q] <= '0;
    end else if (s1_adv) begin
      mem[s1_id_q] <= nxt;
    end
    if (accept) begin
      rd_q <= mem[acc_id];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q    <= 1'b1;
      clr_idx_q     <= '0;
      retry_limit_q <= RETRY_LIMIT_RST;
      cnt_q         <= '0;
      s1_valid_q    <= 1'b0;
      fwd_hit_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + IDX_W'(1);
        if (clr_idx_q == IDX_LAST) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        retry_limit_q <= cfg_i.data;
      end
      if (s1_adv) begin
        cnt_q <= cnt_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= s1_adv && (s1_id_q == acc_id);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q    <= req_i.func;
      s1_id_q      <= acc_id;
      s1_kind_q    <= req_i.change_kind;
      s1_claim_q   <= TICKET_BITS'(req_i.claim_ticket);
      s1_crashed_q <= req_i.crashed;
      fwd_q        <= nxt;
    end
    if (s1_adv) begin
      out_slot_q    <= res_slot;
      out_found_q   <= res_found;
      out_ticket_q  <= res_ticket;
      out_sup_q     <= res_sup;
      out_verdict_q <= res_verdict;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.slot_needed   = out_slot_q;
  assign rsp_o.found         = out_found_q;
  assign rsp_o.ticket_out    = out_ticket_q;
  assign rsp_o.is_superseded = out_sup_q;
  assign rsp_o.verdict       = out_verdict_q;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !req_i.ready)
    else $error("item accepted during clearing pass");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != $past(cnt_q) |-> cnt_q == $past(cnt_q) + TICKET_BITS'(1))
    else $error("ticket counter moved by more than one");

  a_fwd_from_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fwd_hit_q) |-> $past(s1_adv))
    else $error("bypass set without a write-back");

  a_one_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_sup_q |-> !out_found_q && out_verdict_q == VERD_DROPPED
      && !out_slot_q)
    else $error("query result mixed with other fields");

  a_result_follows_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result without an item in the work stage");

endmodule

### test/tb_pending_work_ticket_ledger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pending_work_ticket_ledger
// Self-checking bench for the pending work ticket ledger. A local copy of
// the ledger state predicts every result item as its request is accepted,
// and each result leaving the block is compared field by field in order.
// Directed items cover the special cases. Retry limit phases, a long result
// stall and random job lifecycles follow, with idle bursts on both sides.
// ----------------------------------------------------------------------------
module tb_pending_work_ticket_ledger;
  import ptl_pkg::*;

  localparam int unsigned N_IDS = 1024;
  localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;
  localparam logic [FID_W-1:0] ID_FIRST = '0;
  localparam logic [FID_W-1:0] ID_LAST = '1;
  localparam logic [TKT_W-1:0] TKT_ZERO = '0;
  localparam logic [TKT_W-1:0] TKT_ALL = '1;
  localparam int unsigned SETTLE_CYC = 6;
  localparam int unsigned LONG_HOLD_CYC = 80;

  typedef struct packed {
    logic                 slot_needed;
    logic                 found;
    logic [TKT_W-1:0]     ticket_out;
    logic                 is_superseded;
    logic [VERDICT_W-1:0] verdict;
  } ledger_rsp_t;

  logic clk;
  logic rst_n;

  ptl_req_if req_if ();
  ptl_rsp_if rsp_if ();
  ptl_cfg_if cfg_if ();

  pending_work_ticket_ledger uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  logic               slot_live    [N_IDS];
  logic               slot_queued  [N_IDS];
  logic               slot_kind    [N_IDS];
  logic [TKT_W-1:0]   slot_ticket  [N_IDS];
  logic [TKT_W-1:0]   slot_mark    [N_IDS];
  logic [RETRY_W-1:0] slot_retries [N_IDS];
  logic [TKT_W-1:0]   tkt_ctr;
  logic [RETRY_W-1:0] retry_lim;

  ledger_rsp_t due_results[$];
  ledger_rsp_t want;
  int          errs;
  int          sent_items;
  int          long_hold;
  bit          tx_calm;
  bit          rx_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAIL pending_work_ticket_ledger");
    $finish;
  end

  function automatic logic book_ticket(input logic [FID_W-1:0] id, input logic kind);
    logic fresh;
    fresh = !slot_queued[id];
    slot_queued[id] = 1'b1;
    tkt_ctr = tkt_ctr + 1'b1;
    if (!slot_live[id]) begin
      slot_live[id]    = 1'b1;
      slot_kind[id]    = kind;
      slot_ticket[id]  = tkt_ctr;
      slot_mark[id]    = kind ? tkt_ctr : TKT_ZERO;
      slot_retries[id] = '0;
    end else begin
      if (kind) begin
        slot_kind[id]    = 1'b1;
        slot_mark[id]    = tkt_ctr;
        slot_retries[id] = '0;
      end else if (fresh) begin
        slot_kind[id] = 1'b0;
      end
      slot_ticket[id] = tkt_ctr;
    end
    return fresh;
  endfunction

  function automatic ledger_rsp_t apply_ledger_op(input logic [FUNC_W-1:0] fn,
                                                  input logic [FID_W-1:0] id,
                                                  input logic kind,
                                                  input logic [TKT_W-1:0] claim,
                                                  input logic crashed);
    ledger_rsp_t        r;
    logic               again;
    logic [RETRY_W-1:0] keep;
    r = '0;
    case (fn) inside
      FN_RECORD: begin
        r.slot_needed = book_ticket(id, kind);
      end
      FN_CLAIM, FN_PEEK: begin
        if (fn == FN_CLAIM) slot_queued[id] = 1'b0;
        if (slot_live[id]) begin
          r.found      = 1'b1;
          r.ticket_out = slot_ticket[id];
        end
      end
      FN_SETTLE: begin
        if (slot_live[id] && slot_ticket[id] == claim) slot_live[id] = 1'b0;
      end
      FN_QUERY: begin
        r.is_superseded = !slot_live[id] || slot_mark[id] > claim;
      end
      FN_FAILURE: begin
        if (!slot_live[id]) begin
          r.verdict = VERD_DROPPED;
        end else if (slot_mark[id] > claim) begin
          r.verdict = VERD_SUPERSEDED;
        end else if (crashed && slot_retries[id] >= retry_lim) begin
          slot_live[id]   = 1'b0;
          slot_queued[id] = 1'b0;
          r.verdict       = VERD_GAVE_UP;
        end else begin
          if (crashed) slot_retries[id] = slot_retries[id] + 1'b1;
          again = (slot_mark[id] == claim) ? 1'b1 : slot_kind[id];
          keep = slot_retries[id];
          r.slot_needed = book_ticket(id, again);
          slot_retries[id] = keep;
          r.verdict = VERD_REQUEUED;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [TKT_W-1:0] exp_v,
                             input logic [TKT_W-1:0] act_v);
    if (act_v !== exp_v) begin
      errs++;
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (due_results.size() == 0) begin
        errs++;
        $display("%0t unexpected result: expected none actual ticket %0h verdict %0d",
                 $time, rsp_if.ticket_out, rsp_if.verdict);
      end else begin
        want = due_results.pop_front();
        check_field("slot_needed", TKT_W'(want.slot_needed), TKT_W'(rsp_if.slot_needed));
        check_field("found", TKT_W'(want.found), TKT_W'(rsp_if.found));
        check_field("ticket_out", want.ticket_out, rsp_if.ticket_out);
        check_field("is_superseded", TKT_W'(want.is_superseded),
                    TKT_W'(rsp_if.is_superseded));
        check_field("verdict", TKT_W'(want.verdict), TKT_W'(rsp_if.verdict));
      end
    end
  end

  // result side: random bursts of hold, or one long hold on request
  initial begin
    int n;
    forever begin
      if (long_hold > 0) begin
        n = long_hold;
        long_hold = 0;
        rsp_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [FID_W-1:0] id,
                         input logic kind, input logic [TKT_W-1:0] claim,
                         input logic crashed);
    if (!tx_calm && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.func         <= fn;
    req_if.file_id      <= id;
    req_if.change_kind  <= kind;
    req_if.claim_ticket <= claim;
    req_if.crashed      <= crashed;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    due_results.insert(due_results.size(), apply_ledger_op(fn, id, kind, claim, crashed));
    sent_items++;
  endtask

  task automatic wait_drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [RETRY_W-1:0] lim);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= lim;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    retry_lim = lim;
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [FID_W-1:0] pick_id();
    if ($urandom_range(0, 9) == 0) return FID_W'($urandom_range(0, N_IDS - 1));
    return ($urandom_range(0, 1) ? 10'h3F8 : 10'h000) | FID_W'($urandom_range(0, 7));
  endfunction

  function automatic logic [TKT_W-1:0] pick_claim(input logic [FID_W-1:0] id);
    case ($urandom_range(0, 6))
      0: return slot_ticket[id];
      1: return slot_ticket[id] - 1'b1;
      2: return slot_ticket[id] + 1'b1;
      3: return slot_mark[id];
      4: return tkt_ctr;
      default: return TKT_W'($urandom);
    endcase
  endfunction

  task automatic crash_until_gave_up(input logic [FID_W-1:0] id);
    int guard;
    guard = 0;
    send_op(FN_RECORD, id, 1'b1, TKT_ZERO, 1'b0);
    send_op(FN_CLAIM, id, 1'b0, TKT_ZERO, 1'b0);
    while (slot_live[id] && guard < 20) begin
      send_op(FN_FAILURE, id, 1'b0, slot_mark[id], 1'b1);
      guard++;
    end
  endtask

  task automatic test_record_and_claim();
    send_op(FN_RECORD, ID_FIRST, 1'b1, TKT_ZERO, 1'b0);
    send_op(FN_RECORD, ID_FIRST, 1'b0, TKT_ALL, 1'b1);
    send_op(FN_PEEK, ID_FIRST, 1'b0, TKT_ZERO, 1'b0);
    send_op(FN_CLAIM, ID_FIRST, 1'b1, TKT_ALL, 1'b1);
    send_op(FN_RECORD, ID_FIRST, 1'b0, TKT_ZERO, 1'b0);
    send_op(FN_CLAIM, ID_LAST, 1'b0, TKT_ZERO, 1'b0);
  endtask

  task automatic test_settle_and_query();
    send_op(FN_QUERY, ID_LAST, 1'b0, TKT_ZERO, 1'b0);
    send_op(FN_RECORD, ID_LAST, 1'b1, TKT_ZERO, 1'b0);
    send_op(FN_QUERY, ID_LAST, 1'b0, TKT_ZERO, 1'b0);
    send_op(FN_QUERY, ID_LAST, 1'b1, TKT_ALL, 1'b1);
    send_op(FN_SETTLE, ID_LAST, 1'b0, TKT_ALL, 1'b0);
    send_op(FN_SETTLE, ID_LAST, 1'b0, slot_ticket[ID_LAST], 1'b0);
    send_op(FN_PEEK, ID_LAST, 1'b0, TKT_ZERO, 1'b0);
  endtask

  task automatic test_dispatch_failure();
    logic [TKT_W-1:0] held;
    send_op(FN_FAILURE, 10'd512, 1'b0, TKT_ZERO, 1'b1);
    send_op(FN_RECORD, 10'd512, 1'b1, TKT_ZERO, 1'b0);
    send_op(FN_CLAIM, 10'd512, 1'b0, TKT_ZERO, 1'b0);
    held = slot_ticket[10'd512];
    // deps-only record keeps the content mark equal to the held ticket
    send_op(FN_RECORD, 10'd512, 1'b0, TKT_ZERO, 1'b0);
    send_op(FN_FAILURE, 10'd512, 1'b0, held, 1'b0);
    send_op(FN_RECORD, 10'd512, 1'b1, TKT_ZERO, 1'b0);
    send_op(FN_FAILURE, 10'd512, 1'b0, held, 1'b1);
    send_op(FN_RECORD, 10'd777, 1'b0, TKT_ZERO, 1'b0);
    send_op(FN_CLAIM, 10'd777, 1'b0, TKT_ZERO, 1'b0);
    send_op(FN_FAILURE, 10'd777, 1'b0, slot_ticket[10'd777], 1'b0);
    crash_until_gave_up(10'd300);
  endtask

  task automatic test_unused_funcs();
    send_op(FN_SPARE_A, ID_LAST, 1'b1, TKT_ALL, 1'b1);
    send_op(FN_SPARE_B, ID_FIRST, 1'b1, TKT_ALL, 1'b1);
  endtask

  task automatic test_retry_limits();
    logic [RETRY_W-1:0] lims[3];
    lims = '{4'd0, 4'd15, RETRY_W'($urandom_range(1, 14))};
    foreach (lims[i]) begin
      wait_drain();
      cfg_write(lims[i]);
      crash_until_gave_up(FID_W'(301 + i));
    end
  endtask

  task automatic test_fill_and_stall();
    tx_calm = 1'b1;
    long_hold = LONG_HOLD_CYC;
    repeat (30) send_op($urandom_range(0, 1) ? FN_RECORD : FN_PEEK, pick_id(),
                        1'($urandom_range(0, 1)), TKT_W'($urandom), 1'b0);
    tx_calm = 1'b0;
    wait_drain();
  endtask

  task automatic send_noise();
    logic [FUNC_W-1:0] fn;
    logic [FID_W-1:0]  id;
    id = pick_id();
    if ($urandom_range(0, 19) == 0) fn = $urandom_range(0, 1) ? FN_SPARE_A : FN_SPARE_B;
    else fn = FUNC_W'($urandom_range(FN_RECORD, FN_FAILURE));
    send_op(fn, id, 1'($urandom_range(0, 1)), pick_claim(id), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_lifecycle();
    logic [FID_W-1:0] id;
    logic [TKT_W-1:0] held;
    id = pick_id();
    send_op(FN_RECORD, id, 1'($urandom_range(0, 1)), TKT_W'($urandom),
            1'($urandom_range(0, 1)));
    if ($urandom_range(0, 2) == 0)
      send_op(FN_RECORD, id, 1'($urandom_range(0, 1)), TKT_ZERO, 1'b0);
    if ($urandom_range(0, 3) == 0) send_op(FN_PEEK, id, 1'b0, TKT_W'($urandom), 1'b0);
    send_op(FN_CLAIM, id, 1'($urandom_range(0, 1)), TKT_W'($urandom), 1'b0);
    held = slot_ticket[id];
    if ($urandom_range(0, 3) == 0)
      send_op(FN_RECORD, id, 1'($urandom_range(0, 1)), TKT_ZERO, 1'b0);
    case ($urandom_range(0, 3))
      0: send_op(FN_QUERY, id, 1'b0, $urandom_range(0, 2) ? held : pick_claim(id), 1'b0);
      1: send_op(FN_SETTLE, id, 1'b0, $urandom_range(0, 2) ? held : pick_claim(id), 1'b0);
      default: begin
        repeat ($urandom_range(1, 5)) begin
          send_op(FN_FAILURE, id, 1'b0, $urandom_range(0, 3) ? held : pick_claim(id),
                  $urandom_range(0, 4) != 0);
          if ($urandom_range(0, 1)) begin
            send_op(FN_CLAIM, id, 1'b0, TKT_ZERO, 1'b0);
            held = slot_ticket[id];
          end
        end
      end
    endcase
    if ($urandom_range(0, 1)) send_op(FN_SETTLE, id, 1'b0, slot_ticket[id], 1'b0);
  endtask

  task automatic run_random_phase(input logic [RETRY_W-1:0] lim, input int n_items,
                                  input bit calm);
    int target;
    wait_drain();
    cfg_write(lim);
    tx_calm = calm;
    rx_calm = calm;
    target = sent_items + n_items;
    while (sent_items < target) begin
      if ($urandom_range(0, 3) == 0) send_noise();
      else run_lifecycle();
    end
  endtask

  initial begin
    errs       = 0;
    sent_items = 0;
    long_hold  = 0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    tkt_ctr    = '0;
    retry_lim  = RETRY_LIMIT_RST;
    for (int i = 0; i < N_IDS; i++) begin
      slot_live[i]    = 1'b0;
      slot_queued[i]  = 1'b0;
      slot_kind[i]    = 1'b0;
      slot_ticket[i]  = '0;
      slot_mark[i]    = '0;
      slot_retries[i] = '0;
    end
    rst_n               <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.func         <= FN_RECORD;
    req_if.file_id      <= '0;
    req_if.change_kind  <= 1'b0;
    req_if.claim_ticket <= '0;
    req_if.crashed      <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.data         <= RETRY_LIMIT_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_record_and_claim();
    test_settle_and_query();
    test_dispatch_failure();
    test_unused_funcs();
    test_retry_limits();
    test_fill_and_stall();
    run_random_phase(4'd15, 220, 1'b0);
    run_random_phase(4'd0, 220, 1'b0);
    run_random_phase(RETRY_W'($urandom), 170, 1'b0);
    run_random_phase(RETRY_W'($urandom_range(1, 4)), 130, 1'b1);
    wait_drain();

    if (errs == 0) begin
      $display("PASS pending_work_ticket_ledger");
    end else begin
      $display("FAIL pending_work_ticket_ledger");
    end
    $finish;
  end

endmodule
